// ===== sv/rfc_pkg.sv =====
// shared types, constants and crc function for the rtu reply frame checker
package rfc_pkg;

  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int CODE_W      = 4;
  localparam int CRC_W       = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'hA001;
  localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [CODE_W-1:0] CODE_MASK  = 4'hF;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CRC = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_REPLY_MODE = 1'd1;

  localparam logic [BYTE_W-1:0] EXPECTED_LENGTH_RESET  = 8'd4;
  localparam logic              SHORT_REPLY_MODE_RESET = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   reply_code;
    logic [CRC_W-1:0]    computed_crc;
  } rfc_result_t;

  // reflected crc-16, one byte, unrolled over its eight bits
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/rfc_ifs.sv =====
// valid/ready channel interfaces for frame bytes and check results
interface rfc_byte_if;
  import rfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface rfc_result_if;
  import rfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CODE_W-1:0]   reply_code;
  logic [CRC_W-1:0]    computed_crc;

  modport source (output valid, output status, output reply_code, output computed_crc,
                  input ready);
  modport sink   (input valid, input status, input reply_code, input computed_crc,
                  output ready);
endinterface

// ===== sv/rfc_frame_state.sv =====
// per-frame state: crc accumulator, tail bytes, byte count and end-of-frame check
module rfc_frame_state (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [rfc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        last_byte,
  input  logic [rfc_pkg::BYTE_W-1:0]  expected_length,
  input  logic                        short_reply_mode,
  output logic                        emit,
  output rfc_pkg::rfc_result_t        result
);
  import rfc_pkg::*;

  logic [CRC_W-1:0]  crc_acc, crc_acc_next;
  logic [BYTE_W-1:0] tail0, tail0_next;
  logic [BYTE_W-1:0] tail1, tail1_next;
  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0] second_byte, second_byte_next;
  logic [CRC_W-1:0]  rx_crc;

  always_comb begin
    crc_acc_next     = (byte_count >= 8'd2) ? crc_feed(crc_acc, tail0) : crc_acc;
    tail0_next       = tail1;
    tail1_next       = rx_byte;
    second_byte_next = (byte_count == 8'd1) ? rx_byte : second_byte;
    byte_count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 8'd1;
    rx_crc           = {tail1_next, tail0_next};

    emit = take && last_byte;
    result.computed_crc = crc_acc_next;
    if (byte_count_next != expected_length) begin
      result.status = STATUS_BAD_LEN;
    end else if (rx_crc != crc_acc_next) begin
      result.status = STATUS_BAD_CRC;
    end else begin
      result.status = STATUS_OK;
    end
    if (result.status == STATUS_OK && short_reply_mode) begin
      result.reply_code = second_byte_next[CODE_W-1:0] & CODE_MASK;
    end else begin
      result.reply_code = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc     <= CRC_INIT;
      tail0       <= '0;
      tail1       <= '0;
      byte_count  <= '0;
      second_byte <= '0;
    end else if (take) begin
      if (last_byte) begin
        crc_acc     <= CRC_INIT;
        tail0       <= '0;
        tail1       <= '0;
        byte_count  <= '0;
        second_byte <= '0;
      end else begin
        crc_acc     <= crc_acc_next;
        tail0       <= tail0_next;
        tail1       <= tail1_next;
        byte_count  <= byte_count_next;
        second_byte <= second_byte_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> byte_count == '0 && crc_acc == CRC_INIT)
    else $error("frame state not cleared after last item");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    take && !last_byte && byte_count != COUNT_MAX |=> byte_count == $past(byte_count) + 8'd1)
    else $error("byte count did not advance");

endmodule

// ===== sv/rfc_result_reg.sv =====
// output register holding one check result until the sink takes it
module rfc_result_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  rfc_pkg::rfc_result_t data,
  output logic                 free,
  rfc_result_if.source         replies
);
  import rfc_pkg::*;

  logic        valid;
  rfc_result_t held;

  assign free                 = !valid || replies.ready;
  assign replies.valid        = valid;
  assign replies.status       = held.status;
  assign replies.reply_code   = held.reply_code;
  assign replies.computed_crc = held.computed_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (replies.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !valid || replies.ready)
    else $error("result overwritten before taken");

endmodule

// ===== sv/rtu_reply_frame_checker_core.sv =====
// top level of the rtu reply frame checker
// Checks reply frames that arrive one byte per item, the final byte flagged by
// last_byte. A CRC-16 (reflected, poly 0xA001, init 0xFFFF) runs over all but
// the final two bytes, which carry the received CRC low byte first. On the last
// byte one result comes out: wrong length (checked first), CRC mismatch, or ok,
// plus, when ok, the low nibble of the second byte as reply code in
// short-reply mode. An input register feeds the CRC update and frame check,
// which loads an output register, so bytes are accepted every cycle unless a
// final byte waits in the input register while an earlier result is still
// held; its result then goes into the output register. Configuration must be
// written only between frames; the block itself does not enforce it.
module rtu_reply_frame_checker_core (
  input  logic                             clk,
  input  logic                             rst,
  rfc_byte_if.sink                         frame_bytes,
  rfc_result_if.source                     replies,
  input  logic                             cfg_we,
  input  logic [rfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rfc_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_take;
  logic              res_free;
  logic              emit;
  rfc_result_t       result;
  logic [BYTE_W-1:0] expected_length;
  logic              short_reply_mode;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length  <= EXPECTED_LENGTH_RESET;
      short_reply_mode <= SHORT_REPLY_MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED_LENGTH:  expected_length  <= cfg_data[BYTE_W-1:0];
        REG_SHORT_REPLY_MODE: short_reply_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  assign s1_take           = s1_valid && (!s1_last || res_free);
  assign frame_bytes.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_bytes.ready) begin
      s1_valid <= frame_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_bytes.ready && frame_bytes.valid) begin
      s1_byte <= frame_bytes.rx_byte;
      s1_last <= frame_bytes.last_byte;
    end
  end

  rfc_frame_state u_frame (
    .clk              (clk),
    .rst              (rst),
    .take             (s1_take),
    .rx_byte          (s1_byte),
    .last_byte        (s1_last),
    .expected_length  (expected_length),
    .short_reply_mode (short_reply_mode),
    .emit             (emit),
    .result           (result)
  );

  rfc_result_reg u_result (
    .clk     (clk),
    .rst     (rst),
    .load    (emit),
    .data    (result),
    .free    (res_free),
    .replies (replies)
  );

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_take |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("stalled item lost in input register");

endmodule
